// ===== rtl/core/ght_pkg.sv =====
package ght_pkg;

    // default sizes
    localparam int SLOTS_DEF       = 64;
    localparam int STACK_DEPTH_DEF = 16;
    localparam int GEN_WIDTH_DEF   = 16;

    localparam int CMD_W  = 3;
    localparam int STAT_W = 3;

    // command codes
    localparam logic [CMD_W-1:0] CMD_CREATE = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CHECK  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_POP    = 3'd4;
    localparam logic [CMD_W-1:0] CMD_TOP    = 3'd5;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd6;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
    localparam logic [STAT_W-1:0] STAT_INVALID   = 3'd1;
    localparam logic [STAT_W-1:0] STAT_FULL      = 3'd2;
    localparam logic [STAT_W-1:0] STAT_STK_EMPTY = 3'd3;
    localparam logic [STAT_W-1:0] STAT_STK_FULL  = 3'd4;

    // RAM port strobes
    typedef struct packed {
        logic we;
        logic re;
    } t_ram_ctl;

endpackage

// ===== rtl/core/ght_ram.sv =====
// Simple dual-port RAM, registered read.
module ght_ram #(
    parameter int DEPTH = ght_pkg::SLOTS_DEF,
    parameter int AW    = $clog2(ght_pkg::SLOTS_DEF),
    parameter int DW    = ght_pkg::GEN_WIDTH_DEF
) (
    input  logic               i_clk,
    input  ght_pkg::t_ram_ctl  i_ctl,
    input  logic [AW-1:0]      i_waddr,
    input  logic [DW-1:0]      i_wdata,
    input  logic [AW-1:0]      i_raddr,
    output logic [DW-1:0]      o_rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_ctl.re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/generational_handle_table.sv =====
// Pop, empty-stack top, fresh or table-full create, unused codes and uncreated indexes finish
//   from idle; free-list create, delete, check, push read a slot; top reads the stack, then
//   a slot if created. Clear sweeps one created slot per cycle through the slot RAM port.
// Throughput: one transaction in flight; the next is accepted in the o_done cycle at best.
// Reset: synchronous, active low; free list empty, no slots created, stack empty.
// o_done lasts one cycle; the receiver cannot stall results.
module generational_handle_table #(
    parameter int SLOTS       = ght_pkg::SLOTS_DEF,
    parameter int STACK_DEPTH = ght_pkg::STACK_DEPTH_DEF,
    parameter int GEN_WIDTH   = ght_pkg::GEN_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [ght_pkg::CMD_W-1:0]  i_command,
    input  logic [$clog2(SLOTS)-1:0]   i_handle_index,
    input  logic [GEN_WIDTH-1:0]       i_handle_generation,
    output logic                       o_done,
    output logic [ght_pkg::STAT_W-1:0] o_status,
    output logic [$clog2(SLOTS)-1:0]   o_out_index,
    output logic [GEN_WIDTH-1:0]       o_out_generation,
    output logic                       o_is_valid
);

    localparam int IDX_W   = $clog2(SLOTS);
    localparam int CNT_W   = $clog2(SLOTS + 1);           // holds SLOTS itself
    localparam int SP_W    = $clog2(STACK_DEPTH + 1);
    localparam int SA_W    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int SLOT_DW = CNT_W + GEN_WIDTH;           // {next_free, gen}
    localparam int STK_DW  = IDX_W + GEN_WIDTH;           // {index, gen}

    localparam logic [CNT_W-1:0] EMPTY    = CNT_W'(SLOTS);
    localparam logic [SP_W-1:0]  STK_FULL = SP_W'(STACK_DEPTH);

    // sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SLOT   = 3'd1;   // slot word back for create/delete/check/push
    localparam logic [2:0] S_TOPRD  = 3'd2;   // stack word back for top
    localparam logic [2:0] S_TOPCHK = 3'd3;   // slot word back for top's validity check
    localparam logic [2:0] S_CLR    = 3'd4;   // clear sweep, one slot per cycle

    // control state
    logic [2:0]       r_state,     n_state;
    logic [CNT_W-1:0] r_free_head, n_free_head;
    logic [CNT_W-1:0] r_created,   n_created;
    logic [SP_W-1:0]  r_sp,        n_sp;
    logic             r_done,      n_done;

    // latched transaction and sweep pointer
    logic [ght_pkg::CMD_W-1:0] r_cmd, n_cmd;
    logic [IDX_W-1:0]          r_idx, n_idx;
    logic [GEN_WIDTH-1:0]      r_gen, n_gen;
    logic [IDX_W-1:0]          r_ci,  n_ci;

    // result registers
    logic [ght_pkg::STAT_W-1:0] r_status, n_status;
    logic [IDX_W-1:0]           r_oidx,   n_oidx;
    logic [GEN_WIDTH-1:0]       r_ogen,   n_ogen;
    logic                       r_valid,  n_valid;

    // RAM ports
    ght_pkg::t_ram_ctl    slot_ctl, stk_ctl;
    logic [IDX_W-1:0]     slot_waddr, slot_raddr;
    logic [SLOT_DW-1:0]   slot_wdata, slot_rdata;
    logic [SA_W-1:0]      stk_waddr, stk_raddr;
    logic [STK_DW-1:0]    stk_wdata, stk_rdata;

    logic [CNT_W-1:0]     rd_next;
    logic [GEN_WIDTH-1:0] rd_gen, rd_gen_inc;
    logic [IDX_W-1:0]     stk_idx;
    logic [GEN_WIDTH-1:0] stk_gen;
    logic [SP_W-1:0]      sp_m1;
    logic [IDX_W-1:0]     ci_m1, ci_p1;
    logic [CNT_W-1:0]     created_m1;
    logic                 gen_match;

    ght_ram #(
        .DEPTH (SLOTS),
        .AW    (IDX_W),
        .DW    (SLOT_DW)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_ctl   (slot_ctl),
        .i_waddr (slot_waddr),
        .i_wdata (slot_wdata),
        .i_raddr (slot_raddr),
        .o_rdata (slot_rdata)
    );

    ght_ram #(
        .DEPTH (STACK_DEPTH),
        .AW    (SA_W),
        .DW    (STK_DW)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_ctl   (stk_ctl),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    assign rd_next    = slot_rdata[SLOT_DW-1:GEN_WIDTH];
    assign rd_gen     = slot_rdata[GEN_WIDTH-1:0];
    assign rd_gen_inc = rd_gen + GEN_WIDTH'(1);      // wraps modulo 2^GEN_WIDTH
    assign stk_idx    = stk_rdata[STK_DW-1:GEN_WIDTH];
    assign stk_gen    = stk_rdata[GEN_WIDTH-1:0];
    assign sp_m1      = r_sp - SP_W'(1);
    assign ci_m1      = r_ci - IDX_W'(1);
    assign ci_p1      = r_ci + IDX_W'(1);
    assign created_m1 = r_created - CNT_W'(1);
    assign gen_match  = (rd_gen == r_gen);

    // One transaction at a time: outside the clear sweep a slot write lands on the
    // edge that closes the transaction, so the next read never overlaps it. During the
    // clear sweep the write of slot i and the read of slot i+1 share a cycle
    // but never an address.
    always_comb begin
        n_state     = r_state;
        n_free_head = r_free_head;
        n_created   = r_created;
        n_sp        = r_sp;
        n_cmd       = r_cmd;
        n_idx       = r_idx;
        n_gen       = r_gen;
        n_ci        = r_ci;
        n_done      = 1'b0;
        n_status    = ght_pkg::STAT_OK;
        n_oidx      = '0;
        n_ogen      = '0;
        n_valid     = 1'b0;

        slot_ctl    = '0;
        slot_waddr  = r_idx;
        slot_wdata  = {r_free_head, rd_gen_inc};
        slot_raddr  = i_handle_index;
        stk_ctl     = '0;
        stk_waddr   = r_sp[SA_W-1:0];
        stk_wdata   = {r_idx, r_gen};
        stk_raddr   = sp_m1[SA_W-1:0];

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cmd = i_command;
                    n_idx = i_handle_index;
                    n_gen = i_handle_generation;
                    case (i_command)
                        ght_pkg::CMD_CREATE: begin
                            if (r_free_head < EMPTY) begin
                                slot_ctl.re = 1'b1;
                                slot_raddr  = r_free_head[IDX_W-1:0];
                                n_state     = S_SLOT;
                            end else if (r_created < EMPTY) begin
                                // fresh slot starts at generation 1
                                slot_ctl.we = 1'b1;
                                slot_waddr  = r_created[IDX_W-1:0];
                                slot_wdata  = {EMPTY, GEN_WIDTH'(1)};
                                n_created   = r_created + CNT_W'(1);
                                n_done      = 1'b1;
                                n_oidx      = r_created[IDX_W-1:0];
                                n_ogen      = GEN_WIDTH'(1);
                                n_valid     = 1'b1;
                            end else begin
                                n_done   = 1'b1;
                                n_status = ght_pkg::STAT_FULL;
                            end
                        end
                        ght_pkg::CMD_DELETE,
                        ght_pkg::CMD_CHECK,
                        ght_pkg::CMD_PUSH: begin
                            if (CNT_W'(i_handle_index) < r_created) begin
                                slot_ctl.re = 1'b1;
                                n_state     = S_SLOT;
                            end else begin
                                n_done   = 1'b1;
                                n_status = ght_pkg::STAT_INVALID;
                            end
                        end
                        ght_pkg::CMD_POP: begin
                            n_done = 1'b1;
                            if (r_sp == '0) begin
                                n_status = ght_pkg::STAT_STK_EMPTY;
                            end else begin
                                n_sp = sp_m1;
                            end
                        end
                        ght_pkg::CMD_TOP: begin
                            if (r_sp == '0) begin
                                n_done   = 1'b1;
                                n_status = ght_pkg::STAT_STK_EMPTY;
                            end else begin
                                stk_ctl.re = 1'b1;
                                n_state    = S_TOPRD;
                            end
                        end
                        ght_pkg::CMD_CLEAR: begin
                            n_free_head = EMPTY;
                            if (r_created == '0) begin
                                n_done = 1'b1;
                            end else begin
                                slot_ctl.re = 1'b1;
                                slot_raddr  = '0;
                                n_ci        = '0;
                                n_state     = S_CLR;
                            end
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end

            S_SLOT: begin
                n_done  = 1'b1;
                n_state = S_IDLE;
                case (r_cmd)
                    ght_pkg::CMD_CREATE: begin
                        // pop head of free list
                        n_oidx      = r_free_head[IDX_W-1:0];
                        n_ogen      = rd_gen;
                        n_valid     = 1'b1;
                        n_free_head = rd_next;
                    end
                    ght_pkg::CMD_DELETE: begin
                        if (gen_match) begin
                            slot_ctl.we = 1'b1;
                            n_free_head = CNT_W'(r_idx);
                            n_valid     = 1'b1;
                        end else begin
                            n_status = ght_pkg::STAT_INVALID;
                        end
                    end
                    ght_pkg::CMD_CHECK: begin
                        if (gen_match) begin
                            n_valid = 1'b1;
                        end else begin
                            n_status = ght_pkg::STAT_INVALID;
                        end
                    end
                    ght_pkg::CMD_PUSH: begin
                        if (!gen_match) begin
                            n_status = ght_pkg::STAT_INVALID;
                        end else begin
                            n_valid = 1'b1;
                            if (r_sp >= STK_FULL) begin
                                n_status = ght_pkg::STAT_STK_FULL;
                            end else begin
                                stk_ctl.we = 1'b1;
                                n_sp       = r_sp + SP_W'(1);
                            end
                        end
                    end
                    default: begin
                        n_status = ght_pkg::STAT_OK;
                    end
                endcase
            end

            S_TOPRD: begin
                n_idx = stk_idx;
                n_gen = stk_gen;
                if (CNT_W'(stk_idx) < r_created) begin
                    slot_ctl.re = 1'b1;
                    slot_raddr  = stk_idx;
                    n_state     = S_TOPCHK;
                end else begin
                    n_done  = 1'b1;
                    n_oidx  = stk_idx;
                    n_ogen  = stk_gen;
                    n_state = S_IDLE;
                end
            end

            S_TOPCHK: begin
                n_done  = 1'b1;
                n_oidx  = r_idx;
                n_ogen  = r_gen;
                n_valid = gen_match;
                n_state = S_IDLE;
            end

            S_CLR: begin
                // bump generation, link to the previous slot; slot 0 ends the list
                slot_ctl.we = 1'b1;
                slot_waddr  = r_ci;
                slot_wdata  = {((r_ci == '0) ? EMPTY : CNT_W'(ci_m1)), rd_gen_inc};
                if (CNT_W'(r_ci) == created_m1) begin
                    n_free_head = CNT_W'(r_ci);
                    n_done      = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    slot_ctl.re = 1'b1;
                    slot_raddr  = ci_p1;
                    n_ci        = ci_p1;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_free_head <= EMPTY;
            r_created   <= '0;
            r_sp        <= '0;
            r_done      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_free_head <= n_free_head;
            r_created   <= n_created;
            r_sp        <= n_sp;
            r_done      <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_idx    <= n_idx;
        r_gen    <= n_gen;
        r_ci     <= n_ci;
        r_status <= n_status;
        r_oidx   <= n_oidx;
        r_ogen   <= n_ogen;
        r_valid  <= n_valid;
    end

    assign busy             = (r_state != S_IDLE);
    assign o_done           = r_done;
    assign o_status         = r_status;
    assign o_out_index      = r_oidx;
    assign o_out_generation = r_ogen;
    assign o_is_valid       = r_valid;

    // result strobe only fires once the sequencer is back in idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_state == S_IDLE))
        else $error("result strobe while sequencer busy");

    // free list head is empty or names a created slot
    a_head_created: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_free_head == EMPTY) || (r_free_head < r_created))
        else $error("free list head outside created slots");

    // created count never shrinks
    a_created_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_created >= $past(r_created)))
        else $error("created count decreased");

    // stack pointer stays within depth
    a_sp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= STK_FULL)
        else $error("stack pointer overflow");

endmodule
